>>> rtl/btfa_pkg.sv
// Package for the boundary tag fit allocator.
// Holds status codes, register indexes, fit policy codes, mode codes and the cell contents struct.
// No dependencies.
package btfa_pkg;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolBest  = 2'd1;
  localparam logic [1:0] PolWorst = 2'd2;

  localparam logic RegArena  = 1'b0;
  localparam logic RegPolicy = 1'b1;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  // Contents of one cell of the address-ordered chain.
  typedef struct packed {
    logic        busy;
    logic [15:0] start;
    logic [16:0] payload;
  } blk_t;

endpackage

>>> rtl/btfa_cell.sv
// One cell of the sorted block chain: holds one occupied block or nothing.
// Depends on btfa_pkg. Cells shift toward the tail on insert and toward the head on remove.
module btfa_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           ins_i,
  input  logic           ins_here_i,
  input  logic           shift_r_i,
  input  logic           shift_l_i,
  input  btfa_pkg::blk_t new_i,
  input  btfa_pkg::blk_t left_i,
  input  btfa_pkg::blk_t right_i,
  output btfa_pkg::blk_t blk_o
);

  btfa_pkg::blk_t blk_q, blk_d;

  always_comb begin
    blk_d = blk_q;
    if (ins_i && ins_here_i) begin
      blk_d = new_i;
    end else if (ins_i && shift_r_i) begin
      blk_d = left_i;
    end else if (shift_l_i) begin
      blk_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= '0;
    end else begin
      blk_q <= blk_d;
    end
  end

  assign blk_o = blk_q;

endmodule

>>> rtl/boundary_tag_fit_allocator.sv
// Boundary tag fit allocator: the chain of cells plus the scan sequencer.
// Usage: hold start high with an allocate or free transaction; it is taken while busy is low.
// Occupied blocks live in a chain of MAX_BLOCKS cells kept sorted by address.
// An allocate scans the chain one cell per cycle to find the chosen gap, then
// the cells shift together in the SIns state to open a place at the chosen position.
// A free compares all cells at once in SMul and closes the hole in the next, in SFree.
// An allocate passes through SMul, then SScan for each cell visited, then SIns
// and SDone; with a full table it goes from SMul straight to SDone, and a free
// passes through SMul, SFree and SDone.
// busy stays high until the result is shown.
// Results appear for one cycle with done_o high; the receiver cannot stall.
// After reset the chain is empty, arena_bytes is 4096 and fit_policy is first.
// Configuration writes use cfg_we_i, cfg_idx_i and cfg_wdata_i and take effect
// at once; the user must make them only while the block is idle, as it does not enforce this.
// free_bytes_o saturates at zero when the arena is shrunk below its blocks.
// A new transaction is taken only once the last one is done and busy is low.
// Table full is decided before the scan from the busy bit of the last cell.
module boundary_tag_fit_allocator #(
  parameter int MAX_BLOCKS  = 16,
  parameter int TAG_BYTES   = 32,
  parameter int MIN_PAYLOAD = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        mode_i,
  input  logic [15:0] element_bytes_i,
  input  logic [15:0] element_count_i,
  input  logic [15:0] release_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] grant_offset_o,
  output logic [15:0] grant_bytes_o,
  output logic [15:0] free_bytes_o
);

  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_BLOCKS);
  localparam logic [17:0] Tag = 18'(TAG_BYTES);

  typedef enum logic [2:0] {SIdle, SMul, SScan, SIns, SFree, SDone} state_e;

  state_e        state_q;
  logic [15:0]   arena_q;
  logic [1:0]    policy_q;
  logic          mode_q;
  logic [15:0]   eb_q, ec_q, roff_q;
  logic [32:0]   need_q;
  logic [IW-1:0] idx_q;
  logic [16:0]   from_q;
  logic          found_q;
  logic [16:0]   pgap_q;
  logic [16:0]   pstart_q;
  logic [IW-1:0] ppos_q;
  logic [16:0]   occ_q;
  logic [1:0]    st_q;
  logic [15:0]   goff_q, gby_q;
  logic          done_q;
  logic [MAX_BLOCKS-1:0] hit_q;

  btfa_pkg::blk_t cells [MAX_BLOCKS];
  btfa_pkg::blk_t newb;
  logic [MAX_BLOCKS-1:0] ins_here, shift_r, shift_l;
  logic          do_ins;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    btfa_pkg::blk_t lf, rt;
    if (g == 0) begin : g_l
      assign lf = '0;
    end else begin : g_l
      assign lf = cells[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_r
      assign rt = '0;
    end else begin : g_r
      assign rt = cells[g+1];
    end
    assign ins_here[g] = (ppos_q == IW'(g));
    assign shift_r[g]  = (ppos_q < IW'(g));
    // A cell moves left when it or any cell before it was the freed one.
    assign shift_l[g]  = (state_q == SFree) && (|hit_q[g:0]);
    btfa_cell u_cell (
      .clk_i, .rst_ni,
      .ins_i(do_ins), .ins_here_i(ins_here[g]), .shift_r_i(shift_r[g]),
      .shift_l_i(shift_l[g]), .new_i(newb), .left_i(lf), .right_i(rt),
      .blk_o(cells[g])
    );
  end

  // Scan view of the current cell.
  btfa_pkg::blk_t cur;
  logic           cur_end;
  logic [16:0]    gap_end, gap, gap_from_nx;
  logic [33:0]    need_tag;
  logic           fits, take;
  logic [33:0]    rest;
  logic [16:0]    grant;
  logic [31:0]    prod;

  assign prod = eb_q * ec_q;

  always_comb begin
    cur = (idx_q < LastIdx) ? cells[idx_q[AW-1:0]] : '0;
    cur_end = !cur.busy;
    gap_end = cur_end ? {1'b0, arena_q} : {1'b0, cur.start};
    gap = (gap_end > from_q) ? gap_end - from_q : '0;
    need_tag = {1'b0, need_q} + 34'(Tag);
    fits = {17'd0, gap} >= need_tag;
    if (!found_q) take = 1'b1;
    else if (policy_q == btfa_pkg::PolBest) take = gap < pgap_q;
    else if (policy_q == btfa_pkg::PolWorst) take = gap > pgap_q;
    else take = 1'b0;
    gap_from_nx = 17'({1'b0, cur.start} + Tag + {1'b0, cur.payload});
    rest = {17'd0, pgap_q} - need_tag;
    grant = need_q[16:0];
    if (rest != '0 && rest < 34'(Tag)) grant = 17'(need_q + rest[32:0]);
    newb.busy = 1'b1;
    newb.start = pstart_q[15:0];
    newb.payload = grant;
  end

  assign do_ins = (state_q == SIns) && found_q;
  assign busy   = (state_q != SIdle);

  logic [MAX_BLOCKS-1:0] hit;
  always_comb begin
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      hit[k] = cells[k].busy && (17'({1'b0, cells[k].start} + Tag) == {1'b0, roff_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      arena_q  <= 16'd4096;
      policy_q <= btfa_pkg::PolFirst;
      occ_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      idx_q    <= '0;
      ppos_q   <= LastIdx;
      hit_q    <= '0;
      mode_q   <= btfa_pkg::ModeAlloc;
      eb_q     <= '0;
      ec_q     <= '0;
      roff_q   <= '0;
      need_q   <= '0;
      from_q   <= '0;
      pgap_q   <= '0;
      pstart_q <= '0;
      st_q     <= btfa_pkg::StOk;
      goff_q   <= '0;
      gby_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == btfa_pkg::RegArena) arena_q <= cfg_wdata_i;
        else policy_q <= cfg_wdata_i[1:0];
      end
      unique case (state_q)
        SIdle: begin
          ppos_q <= LastIdx;
          if (start) begin
            mode_q <= mode_i;
            eb_q   <= element_bytes_i;
            ec_q   <= element_count_i;
            roff_q <= release_offset_i;
            goff_q <= '0;
            gby_q  <= '0;
            state_q <= SMul;
          end
        end
        SMul: begin
          if (mode_q == btfa_pkg::ModeFree) begin
            hit_q <= hit;
            st_q <= (|hit) ? btfa_pkg::StOk : btfa_pkg::StUnknown;
            state_q <= SFree;
          end else if (cells[MAX_BLOCKS-1].busy) begin
            st_q <= btfa_pkg::StFull;
            state_q <= SDone;
          end else begin
            need_q <= (prod < 32'(MIN_PAYLOAD)) ? 33'(MIN_PAYLOAD) : {1'b0, prod};
            idx_q <= '0;
            from_q <= '0;
            found_q <= 1'b0;
            state_q <= SScan;
          end
        end
        SScan: begin
          if (fits && take) begin
            found_q <= 1'b1;
            pgap_q <= gap;
            pstart_q <= from_q;
            ppos_q <= idx_q;
          end
          if ((fits && policy_q != btfa_pkg::PolBest && policy_q != btfa_pkg::PolWorst)
              || cur_end) begin
            state_q <= SIns;
          end else begin
            from_q <= gap_from_nx;
            idx_q <= idx_q + 1'b1;
          end
        end
        SIns: begin
          if (found_q) begin
            st_q <= btfa_pkg::StOk;
            goff_q <= 16'(pstart_q + Tag);
            gby_q <= grant[15:0];
            occ_q <= 17'(occ_q + grant + Tag);
          end else begin
            st_q <= btfa_pkg::StNoFit;
          end
          found_q <= 1'b0;
          state_q <= SDone;
        end
        SFree: begin
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (hit_q[k]) begin
              occ_q <= (occ_q >= 17'(cells[k].payload + Tag))
                       ? 17'(occ_q - cells[k].payload - Tag) : '0;
            end
          end
          hit_q <= '0;
          state_q <= SDone;
        end
        SDone: begin
          done_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign status_o = st_q;
  assign grant_offset_o = goff_q;
  assign grant_bytes_o = gby_q;
  assign free_bytes_o = ({1'b0, arena_q} > occ_q) ? 16'({1'b0, arena_q} - occ_q) : '0;

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_q)) else $error("several blocks matched one offset");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result shown twice");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && state_q == SIdle) |-> 1'b0) else $error("busy while idle");

endmodule
